/* src/lmx_pkg.sv */
// lmx_pkg: shared types, constants and helper functions for the lamport mutex node
// used by every module of the block and by the checker
`timescale 1ns / 1ps

package lmx_pkg;

  localparam int NODES_DEFAULT = 7;
  localparam int ACTION_W      = 3;
  localparam int STAMP_W       = 30;
  localparam int NODE_ID_W     = 3;
  localparam int KIND_W        = 2;

  localparam logic [STAMP_W-1:0] IDLE_STAMP = STAMP_W'(999999999);
  localparam logic [STAMP_W-1:0] CLOCK_MAX  = STAMP_W'(999999998);

  // event codes
  localparam logic [ACTION_W-1:0] ACT_LOCAL_REQ = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_LOCAL_REL = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_RX_REQ    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_RX_REL    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RX_ACK    = 3'd4;

  // outgoing message codes
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

  typedef logic [STAMP_W-1:0] stamp_t;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    stamp_t               msg_stamp;
    logic [NODE_ID_W-1:0] sender;
  } lmx_event_t;

  typedef struct packed {
    logic [KIND_W-1:0]    send_kind;
    stamp_t               send_stamp;
    logic [NODE_ID_W-1:0] send_from;
    logic                 grant;
  } lmx_result_t;

  // handshake between the input register and the result register
  typedef struct packed {
    logic ev_valid;
    logic take;
  } lmx_flow_t;

  function automatic stamp_t clamp_clock(input stamp_t x);
    return (x > CLOCK_MAX) ? CLOCK_MAX : x;
  endfunction

  function automatic stamp_t inc_clock(input stamp_t x);
    return (x >= CLOCK_MAX) ? CLOCK_MAX : x + STAMP_W'(1);
  endfunction

  // (a,i) orders after (b,k): larger stamp, or same stamp and larger id
  function automatic logic pair_after(input stamp_t a, input logic [31:0] i,
                                      input stamp_t b, input logic [31:0] k);
    return (a > b) || ((a == b) && (i > k));
  endfunction

endpackage

/* src/lmx_in_stage.sv */
// lmx_in_stage: input register of the lamport mutex node
// depends on lmx_pkg for the event type
`timescale 1ns / 1ps

module lmx_in_stage import lmx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lmx_event_t           in_event,
  input  logic                 take,
  output logic                 ev_valid,
  output lmx_event_t           ev
);

  // held item moves on when the result side can take it
  assign in_stall = ev_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (!in_stall) begin
      ev_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ev <= in_event;
    end
  end

endmodule

/* src/lmx_core.sv */
// lmx_core: clock and request tables, event update and grant evaluation
// depends on lmx_pkg for types, codes and the clock helpers
`timescale 1ns / 1ps

module lmx_core import lmx_pkg::*; #(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [NODE_ID_W-1:0] cfg_wr_data,
  input  lmx_flow_t            flow,
  input  lmx_event_t           ev,
  output lmx_result_t          res
);

  logic [NODE_ID_W-1:0] own_node;
  stamp_t clock_table   [NODES];
  stamp_t request_table [NODES];
  stamp_t clock_next    [NODES];
  stamp_t request_next  [NODES];

  logic   fire;
  logic   own_ok, sender_ok;
  logic   local_req, local_rel, rx, rx_req, rx_rel;
  stamp_t cs, own_clk, own_base, own_clk_new, mine;
  logic   grant_ok;

  assign fire = flow.ev_valid && flow.take;

  always_comb begin
    own_ok    = 32'(own_node) < NODES;
    sender_ok = 32'(ev.sender) < NODES;
    local_req = own_ok && (ev.action == ACT_LOCAL_REQ);
    local_rel = own_ok && (ev.action == ACT_LOCAL_REL);
    rx        = own_ok && sender_ok && ((ev.action == ACT_RX_REQ) ||
                (ev.action == ACT_RX_REL) || (ev.action == ACT_RX_ACK));
    rx_req    = rx && (ev.action == ACT_RX_REQ);
    rx_rel    = rx && (ev.action == ACT_RX_REL);
    cs        = clamp_clock(ev.msg_stamp);

    own_clk = '0;
    for (int j = 0; j < NODES; j++) begin
      if (32'(own_node) == 32'(j)) own_clk = clock_table[j];
    end
    own_base    = (rx && (cs > own_clk)) ? cs : own_clk;
    own_clk_new = inc_clock(own_base);

    // per entry update; own entry written last so it wins when sender is own
    for (int j = 0; j < NODES; j++) begin
      clock_next[j]   = clock_table[j];
      request_next[j] = request_table[j];
      if (rx && (32'(ev.sender) == 32'(j))) begin
        if (cs > clock_table[j]) clock_next[j] = cs;
        if (rx_req) request_next[j] = ev.msg_stamp;
        if (rx_rel) request_next[j] = IDLE_STAMP;
      end
      if (32'(own_node) == 32'(j)) begin
        if (local_req || rx) clock_next[j] = own_clk_new;
        if (local_req) request_next[j] = own_clk_new;
        if (local_rel) request_next[j] = IDLE_STAMP;
      end
    end

    // grant on the updated tables
    mine = IDLE_STAMP;
    for (int j = 0; j < NODES; j++) begin
      if (32'(own_node) == 32'(j)) mine = request_next[j];
    end
    grant_ok = own_ok && (mine != IDLE_STAMP);
    for (int j = 0; j < NODES; j++) begin
      if (32'(own_node) != 32'(j)) begin
        if (pair_after(mine, 32'(own_node), request_next[j], 32'(j))) grant_ok = 1'b0;
        if (pair_after(mine, 32'(own_node), clock_next[j], 32'(j)))   grant_ok = 1'b0;
      end
    end

    res.send_from = own_node;
    res.grant     = grant_ok;
    if (local_req) begin
      res.send_kind  = KIND_REQUEST;
      res.send_stamp = own_clk_new;
    end else if (local_rel) begin
      res.send_kind  = KIND_RELEASE;
      res.send_stamp = own_clk;
    end else if (rx_req) begin
      res.send_kind  = KIND_ACK;
      res.send_stamp = own_clk_new;
    end else begin
      res.send_kind  = KIND_NONE;
      res.send_stamp = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_node <= '0;
    end else if (cfg_wr_en) begin
      own_node <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NODES; j++) begin
        clock_table[j]   <= (j == 0) ? STAMP_W'(1) : '0;
        request_table[j] <= IDLE_STAMP;
      end
    end else if (fire) begin
      for (int j = 0; j < NODES; j++) begin
        clock_table[j]   <= clock_next[j];
        request_table[j] <= request_next[j];
      end
    end
  end

endmodule

/* src/lmx_out_stage.sv */
// lmx_out_stage: result register of the lamport mutex node
// depends on lmx_pkg for the result type
`timescale 1ns / 1ps

module lmx_out_stage import lmx_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         ev_valid,
  input  lmx_result_t  res,
  output logic         take,
  output logic         out_valid,
  input  logic         out_stall,
  output lmx_result_t  out_res
);

  // register is free when empty or its content leaves this cycle
  assign take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ev_valid) begin
      out_res <= res;
    end
  end

endmodule

/* src/lamport_mutex_node.sv */
// lamport_mutex_node: top level of one node of lamport distributed mutual exclusion
// depends on lmx_pkg, lmx_in_stage, lmx_core and lmx_out_stage
// one event per transfer in, one result per event out
`timescale 1ns / 1ps

// Each input transfer is one event (local request, local release, or a received
// request, release or ack with its stamp and sender). The node keeps a logical
// clock and a request stamp for every node and answers each event with exactly
// one result: the message to send, its stamp, the own node id and the grant flag,
// which is evaluated on the tables after the event and checks every peer. The
// block takes one event every clock cycle unless the output stalls; an input
// transfer passes the input register, then the result register. The single
// update pass (table update, clock increment and the grant compare against all
// NODES entries) sits between the two registers. The user writes own_node
// through cfg_wr_en/cfg_wr_data only while no event is in flight; the block does
// not enforce this. A write does not clear the tables, only reset does.

module lamport_mutex_node import lmx_pkg::*; #(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [NODE_ID_W-1:0] cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACTION_W-1:0]  action,
  input  logic [STAMP_W-1:0]   msg_stamp,
  input  logic [NODE_ID_W-1:0] sender,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIND_W-1:0]    send_kind,
  output logic [STAMP_W-1:0]   send_stamp,
  output logic [NODE_ID_W-1:0] send_from,
  output logic                 grant
);

  lmx_event_t  in_event, ev;
  lmx_result_t res, out_res;
  lmx_flow_t   flow;
  logic        ev_valid, take;

  // pack the event fields for the input register
  assign in_event.action    = action;
  assign in_event.msg_stamp = msg_stamp;
  assign in_event.sender    = sender;

  assign flow.ev_valid = ev_valid;
  assign flow.take     = take;

  lmx_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_event (in_event),
    .take     (take),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  // table update and grant evaluation for the held event
  lmx_core #(.NODES(NODES)) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .flow        (flow),
    .ev          (ev),
    .res         (res)
  );

  lmx_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (ev_valid),
    .res       (res),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // unpack the result register onto the payload ports
  assign send_kind  = out_res.send_kind;
  assign send_stamp = out_res.send_stamp;
  assign send_from  = out_res.send_from;
  assign grant      = out_res.grant;

endmodule

/* src/lmx_checker.sv */
// lmx_checker: port level assertions for lamport_mutex_node, bound to the top level
// depends on lmx_pkg for widths and message codes
`timescale 1ns / 1ps

module lmx_checker import lmx_pkg::*; #(
  parameter int NODES = NODES_DEFAULT
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [KIND_W-1:0]    send_kind,
  input logic [STAMP_W-1:0]   send_stamp,
  input logic [NODE_ID_W-1:0] send_from,
  input logic                 grant
);

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(send_kind) && $stable(send_stamp)
      && $stable(send_from) && $stable(grant))
    else $error("stalled result changed");

  // no message means a zero stamp
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (send_kind == KIND_NONE) |-> (send_stamp == '0))
    else $error("stamp present without a message");

  // a node outside the group neither sends nor holds the grant
  a_bad_own: assert property (@(posedge clk) disable iff (rst)
    out_valid && (32'(send_from) >= NODES) |-> (send_kind == KIND_NONE) && !grant)
    else $error("out of range node acted");

endmodule

bind lamport_mutex_node lmx_checker #(.NODES(NODES)) u_lmx_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .send_kind  (send_kind),
  .send_stamp (send_stamp),
  .send_from  (send_from),
  .grant      (grant)
);
